// File: hw/rtl/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, constants and helpers of the boid flock steering block.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int DW        = 32;                  // item field width
    localparam int CW        = 31;                  // config register width
    localparam int CFG_IDX_W = 3;
    localparam int VW        = 48;                  // working vector width
    localparam int CNTW      = 9;
    localparam int UW        = FRAC_BITS + 3;       // signed unit component
    localparam int QB        = FRAC_BITS + 2;       // quotient bits
    localparam int NW        = 30;                  // normalized magnitude bits
    localparam int SQW       = 2 * NW + 2;          // sum of squares width
    localparam int RW        = NW + 1;              // square root width
    localparam int NUMW      = NW + FRAC_BITS + 1;  // dividend width
    localparam int STW       = 5;                   // step counter width

    localparam logic [CNTW-1:0] COUNT_LIMIT = '1;

    typedef logic signed [DW-1:0] t_dw;
    typedef logic signed [VW-1:0] t_vw;
    typedef logic signed [UW-1:0] t_uw;

    localparam t_vw TENTH = VW'((ONE + 5) / 10);
    localparam t_uw ONE_U = UW'(ONE);
    localparam t_dw X_HI  = DW'(80 * ONE);
    localparam t_dw X_LO  = DW'(-80 * ONE);
    localparam t_dw Y_HI  = DW'(30 * ONE);
    localparam t_dw Y_LO  = DW'(15 * ONE);
    localparam t_dw Z_HI  = DW'(110 * ONE);
    localparam t_dw Z_LO  = DW'(10 * ONE);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS, CFG_CRUISE, CFG_DIVE, CFG_ALIGN_W,
        CFG_COHES_W, CFG_SEPAR_W, CFG_CORR_W, CFG_SEEK_W
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_NB_CHK, S_NB_MUL, S_NB_ACC, S_NB_END,
        S_COH_MUL, S_COH_ACC, S_UNIT, S_UWAIT,
        S_SEEK_MUL, S_SEEK_ACC, S_CUR_MUL, S_CUR_ACC,
        S_SPD_MUL, S_SPD_ACC, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_COH, PH_ALI, PH_SEP, PH_TGT, PH_STEER, PH_CUR, PH_FINAL
    } t_phase;

    typedef enum logic [2:0] {
        UV_IDLE, UV_NORM, UV_SQ, UV_SQRT, UV_DLOAD, UV_DIV, UV_DONE
    } t_uv_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_uv_stat;

    function automatic logic [VW-1:0] mag_vw(input t_vw v);
        return v[VW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// File: hw/rtl/bfs_if.sv
// ----------------------------------------------------------------------------
// bfs_in_if / bfs_out_if
// Valid/ready channels carrying bird words in and steering results out.
// ----------------------------------------------------------------------------
interface bfs_in_if;
    import bfs_pkg::*;
    logic            valid;
    logic            ready;
    logic            op;
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] pos_z;
    logic signed [DW-1:0] vel_x;
    logic signed [DW-1:0] vel_y;
    logic signed [DW-1:0] vel_z;
    logic            has_target;
    logic signed [DW-1:0] target_x;
    logic signed [DW-1:0] target_y;
    logic signed [DW-1:0] target_z;
    logic            last;
    modport source (output valid, op, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    has_target, target_x, target_y, target_z, last, input ready);
    modport sink   (input valid, op, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    has_target, target_x, target_y, target_z, last, output ready);
endinterface

interface bfs_out_if;
    import bfs_pkg::*;
    logic            valid;
    logic            ready;
    logic signed [DW-1:0] new_vel_x;
    logic signed [DW-1:0] new_vel_y;
    logic signed [DW-1:0] new_vel_z;
    logic [CNTW-1:0] neighbour_total;
    modport source (output valid, new_vel_x, new_vel_y, new_vel_z, neighbour_total,
                    input ready);
    modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, neighbour_total,
                    output ready);
endinterface

// File: hw/rtl/bfs_mul.sv
// ----------------------------------------------------------------------------
// bfs_mul
// Shared unsigned 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module bfs_mul (
    input  logic                         i_clk,
    input  logic [bfs_pkg::DW-1:0]       i_a,
    input  logic [bfs_pkg::DW-1:0]       i_b,
    output logic [2*bfs_pkg::DW-1:0]     o_prod
);
    import bfs_pkg::*;

    logic [2*DW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (2*DW)'(i_a) * (2*DW)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: hw/rtl/bfs_unitvec.sv
// ----------------------------------------------------------------------------
// bfs_unitvec
// Iterative unit vector: normalize shift, sum of squares, bit-serial square
// root and restoring division per component.
// ----------------------------------------------------------------------------
module bfs_unitvec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bfs_pkg::t_vw      i_v [3],
    output bfs_pkg::t_uw      o_u [3],
    output bfs_pkg::t_uv_stat o_stat
);
    import bfs_pkg::*;

    localparam logic [VW-1:0]  MAG_HI = VW'(1) << NW;
    localparam logic [VW-1:0]  MAG_LO = VW'(1) << (NW - 1);
    localparam logic [SQW-1:0] B_INIT = SQW'(1) << (SQW - 2);

    t_uv_state       r_state, n_state;
    logic [VW-1:0]   r_m [3];
    logic            r_neg [3];
    logic [1:0]      r_i;
    logic [STW-1:0]  r_cnt;
    logic [SQW-1:0]  r_sum, r_x, r_r, r_b;
    logic [RW-1:0]   r_rem;
    logic [QB-1:0]   r_num, r_q;
    t_uw             r_u [3];

    logic [VW-1:0]   mx;
    logic            is_zero;
    logic [2*NW-1:0] sq;
    logic [SQW-1:0]  rb;
    logic [RW-1:0]   len;
    logic [NUMW-1:0] num;
    logic [RW:0]     trial;
    logic            qbit;
    logic [QB-1:0]   q_new;

    always_comb begin
        mx = r_m[0];
        if (r_m[1] > mx) begin
            mx = r_m[1];
        end
        if (r_m[2] > mx) begin
            mx = r_m[2];
        end
    end

    assign is_zero = (i_v[0] == '0) && (i_v[1] == '0) && (i_v[2] == '0);
    assign sq      = (2*NW)'(r_m[r_i][NW-1:0]) * (2*NW)'(r_m[r_i][NW-1:0]);
    assign rb      = r_r + r_b;
    assign len     = r_r[RW-1:0];
    assign num     = NUMW'({r_m[r_i][NW-1:0], {FRAC_BITS{1'b0}}}) + NUMW'(len >> 1);
    assign trial   = {r_rem, r_num[QB-1]};
    assign qbit    = (trial >= {1'b0, len});
    assign q_new   = {r_q[QB-2:0], qbit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= UV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            UV_IDLE: begin
                if (i_start) begin
                    n_state = is_zero ? UV_DONE : UV_NORM;
                end
            end
            UV_NORM: begin
                if (!(mx >= MAG_HI) && !(mx < MAG_LO)) begin
                    n_state = UV_SQ;
                end
            end
            UV_SQ: begin
                if (r_i == 2'd2) begin
                    n_state = UV_SQRT;
                end
            end
            UV_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = UV_DLOAD;
                end
            end
            UV_DLOAD: n_state = UV_DIV;
            UV_DIV: begin
                if (r_cnt == '0) begin
                    n_state = (r_i == 2'd2) ? UV_DONE : UV_DLOAD;
                end
            end
            UV_DONE: n_state = UV_IDLE;
            default: n_state = UV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            UV_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i]   <= mag_vw(i_v[i]);
                        r_neg[i] <= i_v[i][VW-1];
                        r_u[i]   <= '0;
                    end
                end
            end
            UV_NORM: begin
                if (mx >= MAG_HI) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] >> 1;
                    end
                end else if (mx < MAG_LO) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end else begin
                    r_i   <= '0;
                    r_sum <= '0;
                end
            end
            UV_SQ: begin
                r_sum <= r_sum + SQW'(sq);
                if (r_i == 2'd2) begin
                    r_i   <= '0;
                    r_x   <= r_sum + SQW'(sq);
                    r_r   <= '0;
                    r_b   <= B_INIT;
                    r_cnt <= STW'(NW);
                end else begin
                    r_i <= r_i + 2'd1;
                end
            end
            UV_SQRT: begin
                if (r_x >= rb) begin
                    r_x <= r_x - rb;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt - 1'b1;
            end
            UV_DLOAD: begin
                r_rem <= RW'(num[NUMW-1:QB]);
                r_num <= num[QB-1:0];
                r_q   <= '0;
                r_cnt <= STW'(QB - 1);
            end
            UV_DIV: begin
                r_rem <= qbit ? RW'(trial - {1'b0, len}) : RW'(trial);
                r_num <= r_num << 1;
                r_q   <= q_new;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_u[r_i] <= r_neg[r_i] ? -UW'(q_new) : UW'(q_new);
                    r_i      <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_u         = r_u;
    assign o_stat.busy = (r_state != UV_IDLE);
    assign o_stat.done = (r_state == UV_DONE);

endmodule

// File: hw/rtl/boid_flock_steering.sv
// ----------------------------------------------------------------------------
// boid_flock_steering
// Steering update of one bird from its neighbours, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// usage: send a self word (op 0) with position, velocity and dive target,
// then one word per other bird (op 1); set last on the final word. the
// result word carries the new velocity and the neighbour count.
// an other-bird word outside the radius box skips the shared multiplier;
// otherwise the multiplier forms the squared distance in three passes and
// the squared radius in a fourth. the final word runs six unit-vector
// passes, seven when diving (normalize shift, 31-step square root, 3
// divisions each; a zero vector skips them), plus 18 or 21 multiplier
// passes before the result.
// in_ready is low while a word is being worked on. reset clears
// configuration, the self state and the sums; no word is pending afterwards.
// a stalled output holds its word; the block takes new input words meanwhile
// and only waits if the next result is ready first. configuration writes
// take effect at once; the user must do them while idle (not enforced).
// ----------------------------------------------------------------------------
module boid_flock_steering (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bfs_in_if.sink                        i_in,
    bfs_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [bfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bfs_pkg::CW-1:0]        i_cfg_data
);
    import bfs_pkg::*;

    t_state         r_state, n_state;
    t_phase         r_ph;
    logic [CW-1:0]  r_radius, r_cruise, r_dive, r_w_ali, r_w_coh, r_w_sep;
    logic [CW-1:0]  r_w_corr, r_w_seek;
    t_dw            r_self_pos [3];
    t_dw            r_self_vel [3];
    t_dw            r_tgt [3];
    logic           r_tflag;
    t_vw            r_vsum [3];
    t_vw            r_psum [3];
    t_vw            r_osum [3];
    logic [CNTW-1:0] r_count;
    logic signed [DW:0] r_d [3];
    t_dw            r_opos [3];
    t_dw            r_ovel [3];
    logic           r_last;
    logic [2*DW-1:0] r_dsq;
    logic [1:0]     r_ns, r_k, r_j;
    t_vw            r_v [3];
    t_uw            r_ali [3];
    t_uw            r_coh [3];
    t_uw            r_sep [3];
    t_uw            r_steer [3];
    t_uw            r_u [3];
    logic           r_o_valid;
    t_dw            r_o_x, r_o_y, r_o_z;
    logic [CNTW-1:0] r_o_cnt;

    logic           acc;
    logic [VW-1:0]  dmag [3];
    logic           near_box;
    logic [VW-1:0]  nb_mag;
    t_uw            vec_sel, u_op;
    logic [CW-1:0]  w_sel;
    logic [VW-1:0]  umag, pmag;
    logic [DW-1:0]  mul_a, mul_b;
    logic [2*DW-1:0] prod, mq_rnd;
    t_vw            mq, sp;
    logic           uv_start;
    t_uv_stat       uv_stat;
    t_uw            uv_u [3];
    logic           up, out_free, out_load;
    t_vw            fin_x, fin_z;

    function automatic t_dw sat32(input t_vw v);
        if (v > VW'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -VW'(33'sh0_8000_0000)) begin
            return 32'sh8000_0000;
        end
        return DW'(v);
    endfunction

    function automatic t_vw corr(input t_dw p, input t_dw hi, input t_dw lo);
        if (p >= hi) begin
            return -VW'(1);
        end else if (p <= lo) begin
            return VW'(1);
        end
        return '0;
    endfunction

    assign acc         = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dmag[i] = mag_vw(VW'(r_d[i]));
        end
        near_box = (dmag[0] <= VW'(r_radius)) && (dmag[1] <= VW'(r_radius))
                && (dmag[2] <= VW'(r_radius));
    end

    // operand selection for the shared multiplier
    always_comb begin
        case (r_ns)
            2'd0:    nb_mag = dmag[0];
            2'd1:    nb_mag = dmag[1];
            2'd2:    nb_mag = dmag[2];
            default: nb_mag = VW'(r_radius);
        endcase
        case (r_j)
            2'd0:    begin vec_sel = r_ali[r_k];   w_sel = r_w_ali; end
            2'd1:    begin vec_sel = r_coh[r_k];   w_sel = r_w_coh; end
            2'd2:    begin vec_sel = r_sep[r_k];   w_sel = r_w_sep; end
            default: begin
                vec_sel = r_steer[r_k];
                w_sel   = r_tflag ? r_w_seek : r_w_corr;
            end
        endcase
        u_op = ((r_state == S_CUR_MUL) || (r_state == S_CUR_ACC)) ? vec_sel : r_u[r_k];
        umag = mag_vw(VW'(u_op));
        pmag = mag_vw(VW'(r_self_pos[r_k]));
        case (r_state)
            S_NB_MUL:   begin mul_a = nb_mag[DW-1:0];   mul_b = nb_mag[DW-1:0]; end
            S_COH_MUL:  begin mul_a = DW'(r_count);     mul_b = pmag[DW-1:0]; end
            S_SEEK_MUL: begin mul_a = umag[DW-1:0];     mul_b = DW'(r_dive); end
            S_CUR_MUL:  begin mul_a = umag[DW-1:0];     mul_b = DW'(w_sel); end
            S_SPD_MUL:  begin
                mul_a = umag[DW-1:0];
                mul_b = DW'(r_tflag ? r_dive : r_cruise);
            end
            default:    begin mul_a = '0;               mul_b = '0; end
        endcase
    end

    bfs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // rounded weight product, halves away from zero
    assign mq_rnd = prod + (2*DW)'(1 << (FRAC_BITS - 1));
    assign mq     = u_op[UW-1] ? -t_vw'(mq_rnd[FRAC_BITS +: VW]) : t_vw'(mq_rnd[FRAC_BITS +: VW]);
    assign sp     = r_self_pos[r_k][DW-1] ? -t_vw'(prod[VW-1:0]) : t_vw'(prod[VW-1:0]);

    assign uv_start = (r_state == S_UNIT);

    bfs_unitvec u_unitvec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (uv_start),
        .i_v     (r_v),
        .o_u     (uv_u),
        .o_stat  (uv_stat)
    );

    assign up       = (r_u[0] == '0) && (r_u[1] == ONE_U) && (r_u[2] == '0);
    assign fin_x    = r_v[0] + (up ? TENTH : '0);
    assign fin_z    = r_v[2] + (up ? TENTH : '0);
    assign out_free = !r_o_valid || o_out.ready;
    assign out_load = (r_state == S_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_in.op) begin
                        n_state = S_NB_CHK;
                    end else if (i_in.last) begin
                        n_state = S_COH_MUL;
                    end
                end
            end
            S_NB_CHK:   n_state = near_box ? S_NB_MUL : S_NB_END;
            S_NB_MUL:   n_state = S_NB_ACC;
            S_NB_ACC:   n_state = (r_ns == 2'd3) ? S_NB_END : S_NB_MUL;
            S_NB_END:   n_state = r_last ? S_COH_MUL : S_IDLE;
            S_COH_MUL:  n_state = S_COH_ACC;
            S_COH_ACC:  n_state = (r_k == 2'd2) ? S_UNIT : S_COH_MUL;
            S_UNIT:     n_state = S_UWAIT;
            S_UWAIT: begin
                if (uv_stat.done) begin
                    case (r_ph)
                        PH_TGT:   n_state = S_SEEK_MUL;
                        PH_STEER: n_state = S_CUR_MUL;
                        PH_CUR:   n_state = S_SPD_MUL;
                        PH_FINAL: n_state = S_OUT;
                        default:  n_state = S_UNIT;
                    endcase
                end
            end
            S_SEEK_MUL: n_state = S_SEEK_ACC;
            S_SEEK_ACC: n_state = (r_k == 2'd2) ? S_UNIT : S_SEEK_MUL;
            S_CUR_MUL:  n_state = S_CUR_ACC;
            S_CUR_ACC:  n_state = (r_k == 2'd2 && r_j == 2'd3) ? S_UNIT : S_CUR_MUL;
            S_SPD_MUL:  n_state = S_SPD_ACC;
            S_SPD_ACC:  n_state = (r_k == 2'd2) ? S_UNIT : S_SPD_MUL;
            S_OUT:      n_state = out_free ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph      <= PH_COH;
            r_radius  <= '0;
            r_cruise  <= '0;
            r_dive    <= '0;
            r_w_ali   <= '0;
            r_w_coh   <= '0;
            r_w_sep   <= '0;
            r_w_corr  <= '0;
            r_w_seek  <= '0;
            r_tflag   <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_k       <= '0;
            r_j       <= '0;
            r_ns      <= '0;
            for (int i = 0; i < 3; i++) begin
                r_self_pos[i] <= '0;
                r_self_vel[i] <= '0;
                r_tgt[i]      <= '0;
                r_vsum[i]     <= '0;
                r_psum[i]     <= '0;
                r_osum[i]     <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:  r_radius <= i_cfg_data;
                    CFG_CRUISE:  r_cruise <= i_cfg_data;
                    CFG_DIVE:    r_dive   <= i_cfg_data;
                    CFG_ALIGN_W: r_w_ali  <= i_cfg_data;
                    CFG_COHES_W: r_w_coh  <= i_cfg_data;
                    CFG_SEPAR_W: r_w_sep  <= i_cfg_data;
                    CFG_CORR_W:  r_w_corr <= i_cfg_data;
                    CFG_SEEK_W:  r_w_seek <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_last <= i_in.last;
                        r_k    <= '0;
                        r_ns   <= '0;
                        r_dsq  <= '0;
                        if (!i_in.op) begin
                            r_self_pos[0] <= i_in.pos_x;
                            r_self_pos[1] <= i_in.pos_y;
                            r_self_pos[2] <= i_in.pos_z;
                            r_self_vel[0] <= i_in.vel_x;
                            r_self_vel[1] <= i_in.vel_y;
                            r_self_vel[2] <= i_in.vel_z;
                            r_tgt[0]      <= i_in.target_x;
                            r_tgt[1]      <= i_in.target_y;
                            r_tgt[2]      <= i_in.target_z;
                            r_tflag       <= i_in.has_target;
                            r_count       <= '0;
                            for (int i = 0; i < 3; i++) begin
                                r_vsum[i] <= '0;
                                r_psum[i] <= '0;
                                r_osum[i] <= '0;
                            end
                        end else begin
                            r_d[0]  <= (DW+1)'(i_in.pos_x) - (DW+1)'(r_self_pos[0]);
                            r_d[1]  <= (DW+1)'(i_in.pos_y) - (DW+1)'(r_self_pos[1]);
                            r_d[2]  <= (DW+1)'(i_in.pos_z) - (DW+1)'(r_self_pos[2]);
                            r_opos[0] <= i_in.pos_x;
                            r_opos[1] <= i_in.pos_y;
                            r_opos[2] <= i_in.pos_z;
                            r_ovel[0] <= i_in.vel_x;
                            r_ovel[1] <= i_in.vel_y;
                            r_ovel[2] <= i_in.vel_z;
                        end
                    end
                end
                S_NB_ACC: begin
                    if (r_ns != 2'd3) begin
                        r_dsq <= r_dsq + prod;
                        r_ns  <= r_ns + 2'd1;
                    end else if ((r_dsq <= prod) && (r_count < COUNT_LIMIT)) begin
                        r_count <= r_count + 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_vsum[i] <= r_vsum[i] + VW'(r_ovel[i]);
                            r_psum[i] <= r_psum[i] + VW'(r_opos[i]);
                            r_osum[i] <= r_osum[i] + VW'(r_d[i]);
                        end
                    end
                end
                S_COH_ACC: begin
                    r_v[r_k] <= r_psum[r_k] - sp;
                    if (r_k == 2'd2) begin
                        r_k  <= '0;
                        r_ph <= PH_COH;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_UWAIT: begin
                    if (uv_stat.done) begin
                        case (r_ph)
                            PH_COH: begin
                                r_coh <= uv_u;
                                r_v   <= r_vsum;
                                r_ph  <= PH_ALI;
                            end
                            PH_ALI: begin
                                r_ali <= uv_u;
                                for (int i = 0; i < 3; i++) begin
                                    r_v[i] <= -r_osum[i];
                                end
                                r_ph <= PH_SEP;
                            end
                            PH_SEP: begin
                                r_sep <= uv_u;
                                if (r_tflag) begin
                                    for (int i = 0; i < 3; i++) begin
                                        r_v[i] <= VW'(r_tgt[i]) - VW'(r_self_pos[i]);
                                    end
                                    r_ph <= PH_TGT;
                                end else begin
                                    // box boundary correction
                                    r_v[0] <= corr(r_self_pos[0], X_HI, X_LO);
                                    r_v[1] <= corr(r_self_pos[1], Y_HI, Y_LO);
                                    r_v[2] <= corr(r_self_pos[2], Z_HI, Z_LO);
                                    r_ph   <= PH_STEER;
                                end
                            end
                            PH_TGT: begin
                                r_u <= uv_u;
                                r_k <= '0;
                            end
                            PH_STEER: begin
                                r_steer <= uv_u;
                                for (int i = 0; i < 3; i++) begin
                                    r_v[i] <= VW'(r_self_vel[i]);
                                end
                                r_k <= '0;
                                r_j <= '0;
                            end
                            PH_CUR: begin
                                r_u <= uv_u;
                                r_k <= '0;
                            end
                            default: begin
                                r_u <= uv_u;
                            end
                        endcase
                    end
                end
                S_SEEK_ACC: begin
                    r_v[r_k] <= mq - VW'(r_self_vel[r_k]);
                    if (r_k == 2'd2) begin
                        r_k  <= '0;
                        r_ph <= PH_STEER;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_CUR_ACC: begin
                    r_v[r_k] <= r_v[r_k] + mq;
                    if (r_j == 2'd3) begin
                        r_j <= '0;
                        if (r_k == 2'd2) begin
                            r_k  <= '0;
                            r_ph <= PH_CUR;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_SPD_ACC: begin
                    r_v[r_k] <= mq;
                    if (r_k == 2'd2) begin
                        r_k  <= '0;
                        r_ph <= PH_FINAL;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                default: begin
                end
            endcase

            if (out_load) begin
                r_o_valid <= 1'b1;
                r_o_x     <= sat32(fin_x);
                r_o_y     <= sat32(r_v[1]);
                r_o_z     <= sat32(fin_z);
                r_o_cnt   <= r_count;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.new_vel_x       = r_o_x;
    assign o_out.new_vel_y       = r_o_y;
    assign o_out.new_vel_z       = r_o_z;
    assign o_out.neighbour_total = r_o_cnt;

    a_self_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_in.op) |=> (r_count == '0))
        else $error("self word did not clear the neighbour count");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_OUT))
        else $error("result word raised outside the output step");

    a_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UNIT) |-> !uv_stat.busy)
        else $error("unit vector started while busy");

endmodule
